// ===== sv/indexed_list_insert_delete_search_core_assert.svh =====
`ifndef INDEXED_LIST_INSERT_DELETE_SEARCH_CORE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ILIST_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ilist check failed");

// Next-cycle implication, checked outside reset.
`define ILIST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ilist check failed");

`endif

// ===== sv/ilist_pkg.sv =====
package ilist_pkg;

    localparam int DEPTH  = 128;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int FUNC_W = 2;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 7;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 8;

    // Width in which a position and the count are compared.
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_PUT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic                    we;
        logic [ADDR_W-1:0]       waddr;
        logic signed [VAL_W-1:0] wdata;
        logic [ADDR_W-1:0]       raddr;
    } t_mem_req;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } t_seq_stat;

endpackage

// ===== sv/ilist_if.sv =====
interface ilist_req_if;
    logic                              valid;
    logic                              ready;
    logic [ilist_pkg::FUNC_W-1:0]      func;
    logic signed [ilist_pkg::VAL_W-1:0] value;
    logic [ilist_pkg::POS_W-1:0]       position;

    modport source (output valid, func, value, position, input ready);
    modport sink (input valid, func, value, position, output ready);
endinterface

interface ilist_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ilist_pkg::STAT_W-1:0] status;
    logic                         found;
    logic [ilist_pkg::LEN_W-1:0]  length;

    modport source (output valid, status, found, length, input ready);
    modport sink (input valid, status, found, length, output ready);
endinterface

// ===== sv/ilist_ram.sv =====
module ilist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/ilist_seq.sv =====
module ilist_seq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    ilist_req_if.sink                          i_req,
    ilist_rsp_if.source                        o_rsp,
    output ilist_pkg::t_mem_req                o_mem,
    input  logic signed [ilist_pkg::VAL_W-1:0] i_rdata,
    output ilist_pkg::t_seq_stat               o_stat
);

    ilist_pkg::t_state r_state, n_state;

    logic [ilist_pkg::FUNC_W-1:0]       r_op, n_op;
    logic signed [ilist_pkg::VAL_W-1:0] r_val, n_val;
    logic [ilist_pkg::ADDR_W-1:0]       r_pos, n_pos;
    logic [ilist_pkg::CNT_W-1:0]        r_count, n_count;
    logic [ilist_pkg::ADDR_W-1:0]       r_rptr, n_rptr;
    logic [ilist_pkg::ADDR_W-1:0]       r_rend, n_rend;
    logic [ilist_pkg::ADDR_W-1:0]       r_wptr, n_wptr;
    logic                               r_rd_on, n_rd_on;
    logic                               r_pend, n_pend;
    logic                               r_found, n_found;
    logic [ilist_pkg::STAT_W-1:0]       r_status, n_status;

    logic                         accept;
    logic [ilist_pkg::CMP_W-1:0]  pos_x;
    logic [ilist_pkg::CMP_W-1:0]  cnt_x;
    logic [ilist_pkg::CMP_W:0]    pos_nx;
    logic                         ins_full;
    logic                         ins_range;
    logic                         del_range;
    logic                         start_move;
    logic                         move_done;

    assign accept    = i_req.valid && i_req.ready;
    assign pos_x     = ilist_pkg::CMP_W'(i_req.position);
    assign cnt_x     = ilist_pkg::CMP_W'(r_count);
    assign pos_nx    = {1'b0, pos_x} + 1'b1;
    assign ins_full  = r_count >= ilist_pkg::CNT_W'(ilist_pkg::DEPTH);
    assign ins_range = pos_x > cnt_x;
    assign del_range = pos_x >= cnt_x;
    assign move_done = !r_rd_on && !r_pend;

    always_comb begin
        case (i_req.func)
            ilist_pkg::FUNC_INSERT: start_move = !ins_full && !ins_range;
            ilist_pkg::FUNC_DELETE: start_move = !del_range;
            ilist_pkg::FUNC_SEARCH: start_move = 1'b1;
            default:                start_move = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ilist_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = start_move ? ilist_pkg::S_MOVE : ilist_pkg::S_RESP;
                end
            end
            ilist_pkg::S_MOVE: begin
                if (move_done) begin
                    n_state = (r_op == ilist_pkg::FUNC_INSERT) ? ilist_pkg::S_PUT
                                                               : ilist_pkg::S_RESP;
                end
            end
            ilist_pkg::S_PUT: n_state = ilist_pkg::S_RESP;
            ilist_pkg::S_RESP: begin
                if (o_rsp.ready) begin
                    n_state = ilist_pkg::S_IDLE;
                end
            end
            default: n_state = ilist_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        n_op     = r_op;
        n_val    = r_val;
        n_pos    = r_pos;
        n_count  = r_count;
        n_rptr   = r_rptr;
        n_rend   = r_rend;
        n_wptr   = r_wptr;
        n_rd_on  = r_rd_on;
        n_pend   = r_pend;
        n_found  = r_found;
        n_status = r_status;

        o_mem.we    = 1'b0;
        o_mem.waddr = r_wptr;
        o_mem.wdata = i_rdata;
        o_mem.raddr = r_rptr;

        i_req.ready  = (r_state == ilist_pkg::S_IDLE);
        o_rsp.valid  = (r_state == ilist_pkg::S_RESP);
        o_rsp.status = r_status;
        o_rsp.found  = r_found;
        o_rsp.length = ilist_pkg::LEN_W'(r_count);

        case (r_state)
            ilist_pkg::S_IDLE: begin
                if (accept) begin
                    n_op     = i_req.func;
                    n_val    = i_req.value;
                    n_pos    = ilist_pkg::ADDR_W'(i_req.position);
                    n_found  = 1'b0;
                    n_status = ilist_pkg::ST_OK;
                    n_rd_on  = 1'b0;
                    n_pend   = 1'b0;
                    case (i_req.func)
                        ilist_pkg::FUNC_INSERT: begin
                            if (ins_full) begin
                                n_status = ilist_pkg::ST_FULL;
                            end else if (ins_range) begin
                                n_status = ilist_pkg::ST_RANGE;
                            end else begin
                                // Walk down from the last entry to the insert point.
                                n_rptr  = ilist_pkg::ADDR_W'(r_count - 1'b1);
                                n_rend  = ilist_pkg::ADDR_W'(i_req.position);
                                n_rd_on = (pos_x != cnt_x);
                            end
                        end
                        ilist_pkg::FUNC_DELETE: begin
                            if (del_range) begin
                                n_status = ilist_pkg::ST_RANGE;
                            end else begin
                                // Walk up from the entry after the hole to the last one.
                                n_rptr  = ilist_pkg::ADDR_W'(pos_nx);
                                n_rend  = ilist_pkg::ADDR_W'(r_count - 1'b1);
                                n_rd_on = (pos_nx < {1'b0, cnt_x});
                            end
                        end
                        ilist_pkg::FUNC_SEARCH: begin
                            n_rptr  = '0;
                            n_rend  = ilist_pkg::ADDR_W'(r_count - 1'b1);
                            n_rd_on = (r_count != '0);
                        end
                        default: begin
                            n_rd_on = 1'b0;
                        end
                    endcase
                end
            end
            ilist_pkg::S_MOVE: begin
                // Data read last cycle is either compared or written one slot over.
                if (r_pend) begin
                    if (r_op == ilist_pkg::FUNC_SEARCH) begin
                        if (i_rdata == r_val) begin
                            n_found = 1'b1;
                        end
                    end else begin
                        o_mem.we = 1'b1;
                    end
                end
                if (r_rd_on) begin
                    n_pend = 1'b1;
                    if (r_op == ilist_pkg::FUNC_INSERT) begin
                        n_wptr = r_rptr + 1'b1;
                    end else begin
                        n_wptr = r_rptr - 1'b1;
                    end
                    if (r_rptr == r_rend) begin
                        n_rd_on = 1'b0;
                    end else if (r_op == ilist_pkg::FUNC_INSERT) begin
                        n_rptr = r_rptr - 1'b1;
                    end else begin
                        n_rptr = r_rptr + 1'b1;
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (move_done && r_op == ilist_pkg::FUNC_DELETE) begin
                    n_count = r_count - 1'b1;
                end
            end
            ilist_pkg::S_PUT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_pos;
                o_mem.wdata = r_val;
                n_count     = r_count + 1'b1;
            end
            ilist_pkg::S_RESP: begin
                n_rd_on = 1'b0;
            end
            default: begin
                n_rd_on = 1'b0;
            end
        endcase

        o_stat.busy  = (r_state != ilist_pkg::S_IDLE);
        o_stat.count = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ilist_pkg::S_IDLE;
            r_count <= '0;
            r_rd_on <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rd_on <= n_rd_on;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_pos    <= n_pos;
        r_rptr   <= n_rptr;
        r_rend   <= n_rend;
        r_wptr   <= n_wptr;
        r_found  <= n_found;
        r_status <= n_status;
    end

endmodule

// ===== sv/indexed_list_insert_delete_search_core.sv =====
// Packed list of up to DEPTH signed 32-bit words with insert, delete and search.
// Each request word on i_req carries an operation (insert, delete or search), a
// value and a position, and yields exactly one response word on o_rsp with a
// status (ok, list full, position out of range), a found flag and the new list
// length. The list is held in one single-port-write, registered-read RAM, and a
// sequencer walks it one entry per cycle, so one request is in flight at a time.
// After acceptance, an insert shifts the entries from the insert point up and
// then writes the new value, a delete shifts the entries past the hole down, a
// search compares every entry, and a rejected request or the unused function
// code goes straight to the response. The response word is held until taken,
// after which the next request is accepted. Entries past the current length
// are never read, so the RAM needs no clearing after reset and the block is
// ready as soon as reset is released.
`include "indexed_list_insert_delete_search_core_assert.svh"

module indexed_list_insert_delete_search_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ilist_req_if.sink   i_req,
    ilist_rsp_if.source o_rsp
);

    ilist_pkg::t_mem_req               mem_req;
    ilist_pkg::t_seq_stat              seq_stat;
    logic [ilist_pkg::VAL_W-1:0]       ram_rdata;
    logic signed [ilist_pkg::VAL_W-1:0] rdata;

    assign rdata = ram_rdata;

    // The sequencer owns the length, the request registers and the response
    // register, and drives one RAM read and at most one RAM write per cycle.
    // During a shift, reads and writes are always at least one entry apart, so
    // the RAM never sees a read and a write to the same entry in a shift cycle.
    ilist_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_mem   (mem_req),
        .i_rdata (rdata),
        .o_stat  (seq_stat)
    );

    // List storage.
    ilist_ram #(
        .WIDTH (ilist_pkg::VAL_W),
        .DEPTH (ilist_pkg::DEPTH),
        .AW    (ilist_pkg::ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (ram_rdata)
    );

    // The length never exceeds the capacity.
    `ILIST_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, seq_stat.count <= ilist_pkg::CNT_W'(ilist_pkg::DEPTH))

    // The length moves by one step, and only as a response is being offered.
    `ILIST_ASSERT_NOW(a_count_step, i_clk, i_rst_n, seq_stat.count != $past(seq_stat.count), o_rsp.valid && (seq_stat.count == $past(seq_stat.count) + 1'b1 || seq_stat.count == $past(seq_stat.count) - 1'b1))

    // No request is taken while a response is pending or the RAM walk runs.
    `ILIST_ASSERT_NOW(a_one_in_flight, i_clk, i_rst_n, seq_stat.busy, !i_req.ready)

    // A write to the list only happens while a request is being worked on.
    `ILIST_ASSERT_NOW(a_write_busy, i_clk, i_rst_n, mem_req.we, seq_stat.busy && !o_rsp.valid)

endmodule

// ===== dv/tb_indexed_list_insert_delete_search_core.sv =====
module tb_indexed_list_insert_delete_search_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Function code 3 is left unused by the block and must act as a no-op.
    localparam logic [ilist_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic signed [ilist_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [ilist_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    localparam int GAP_MAX        = 12;
    // The directed tests and the fill test add a little under 300 more words.
    localparam int RANDOM_ITEMS   = 910;
    // The slowest request is a search of a full list or a front insert on a list
    // one short of full, and the end-of-run quiet period covers one of those.
    localparam int SETTLE_CYCLES  = ilist_pkg::DEPTH + 16;
    // Cycles with no word moving on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 20 * (ilist_pkg::DEPTH + 4 + 2 * GAP_MAX);
    localparam int MAX_REPORTS    = 40;

    typedef struct packed {
        logic [ilist_pkg::STAT_W-1:0] status;
        logic                         found;
        logic [ilist_pkg::LEN_W-1:0]  length;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    ilist_req_if req_if ();
    ilist_rsp_if rsp_if ();

    indexed_list_insert_delete_search_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the list contents and length, updated when a request word
    // is accepted. Entries at or above shadow_len are never looked at.
    logic signed [ilist_pkg::VAL_W-1:0] shadow_words [ilist_pkg::DEPTH];
    int                                 shadow_len = 0;

    // Responses the block still owes, oldest first.
    t_list_result pending_results [$];

    int error_count  = 0;
    int report_lines = 0;
    int idle_cycles  = 0;

    // When set, the matching side runs back to back with no idle cycles.
    bit req_quiet = 1'b0;
    bit rsp_quiet = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Applies one operation to the shadow list and returns the response word the
    // block must produce for it.
    function automatic t_list_result apply_list_op(
        input logic [ilist_pkg::FUNC_W-1:0]       func,
        input logic signed [ilist_pkg::VAL_W-1:0] value,
        input logic [ilist_pkg::POS_W-1:0]        position
    );
        t_list_result r;
        int           slot;
        r.status = ilist_pkg::ST_OK;
        r.found  = 1'b0;
        case (func)
            ilist_pkg::FUNC_INSERT: begin
                // A full list is reported ahead of a bad position.
                if (shadow_len >= ilist_pkg::DEPTH) begin
                    r.status = ilist_pkg::ST_FULL;
                end else if (int'(position) > shadow_len) begin
                    r.status = ilist_pkg::ST_RANGE;
                end else begin
                    for (slot = shadow_len; slot > int'(position); slot--)
                        shadow_words[slot] = shadow_words[slot - 1];
                    shadow_words[position] = value;
                    shadow_len++;
                end
            end
            ilist_pkg::FUNC_DELETE: begin
                if (int'(position) >= shadow_len) begin
                    r.status = ilist_pkg::ST_RANGE;
                end else begin
                    for (slot = int'(position); slot + 1 < shadow_len; slot++)
                        shadow_words[slot] = shadow_words[slot + 1];
                    shadow_len--;
                end
            end
            ilist_pkg::FUNC_SEARCH: begin
                for (slot = 0; slot < shadow_len; slot++)
                    if (shadow_words[slot] == value)
                        r.found = 1'b1;
            end
            default: begin
            end
        endcase
        r.length = ilist_pkg::LEN_W'(shadow_len);
        return r;
    endfunction

    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (report_lines < MAX_REPORTS) begin
            $display("ERROR at %0t ns: %s", $time, msg);
            report_lines++;
        end
    endtask

    // Offers one request word and returns at the clock edge that accepts it.
    // Valid is left high on return so that a following word with no gap goes
    // out back to back; it is only lowered ahead of an idle stretch.
    task automatic send_word(
        input logic [ilist_pkg::FUNC_W-1:0]       func,
        input logic signed [ilist_pkg::VAL_W-1:0] value,
        input logic [ilist_pkg::POS_W-1:0]        position
    );
        int gap;
        gap = draw_gap(req_quiet);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.func     <= func;
        req_if.value    <= value;
        req_if.position <= position;
        // Ready is looked at mid-cycle, where it is settled; if it is high, the
        // next rising edge moves the word.
        @(negedge i_clk);
        while (!req_if.ready) @(negedge i_clk);
        @(posedge i_clk);
        pending_results.push_back(apply_list_op(func, value, position));
    endtask

    // Stops offering requests and holds off until every owed response is in.
    // It always waits for a clock edge first, so valid is never lowered and
    // raised again within one time step.
    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Walks the out-of-range rejections on a short list, every operation, the value
    // extremes and the unused function code.
    task automatic test_directed_edges();
        send_word(ilist_pkg::FUNC_SEARCH, 32'sd0, 7'd0);
        send_word(ilist_pkg::FUNC_DELETE, 32'sd0, 7'd0);
        send_word(ilist_pkg::FUNC_INSERT, 32'sd1, 7'd1);
        send_word(ilist_pkg::FUNC_INSERT, 32'sd1, 7'd127);
        send_word(FUNC_UNUSED, 32'sd0, 7'd0);
        // Build [-1, MIN, 0, MAX] through append, middle and front inserts.
        send_word(ilist_pkg::FUNC_INSERT, VAL_MIN, 7'd0);
        send_word(ilist_pkg::FUNC_INSERT, VAL_MAX, 7'd1);
        send_word(ilist_pkg::FUNC_INSERT, 32'sd0, 7'd1);
        send_word(ilist_pkg::FUNC_INSERT, -32'sd1, 7'd0);
        send_word(ilist_pkg::FUNC_SEARCH, VAL_MIN, 7'd0);
        send_word(ilist_pkg::FUNC_SEARCH, VAL_MAX, 7'd127);
        send_word(ilist_pkg::FUNC_SEARCH, -32'sd1, 7'd3);
        send_word(ilist_pkg::FUNC_SEARCH, 32'sd0, 7'd64);
        send_word(ilist_pkg::FUNC_SEARCH, 32'sd1, 7'd0);
        // A delete at the length, and an insert just past it, are out of range.
        send_word(ilist_pkg::FUNC_DELETE, 32'sd0, 7'd4);
        send_word(ilist_pkg::FUNC_DELETE, VAL_MAX, 7'd127);
        send_word(ilist_pkg::FUNC_INSERT, 32'sd9, 7'd5);
        send_word(FUNC_UNUSED, -32'sd1, 7'd127);
        send_word(ilist_pkg::FUNC_DELETE, 32'sd0, 7'd3);
        send_word(ilist_pkg::FUNC_DELETE, 32'sd0, 7'd0);
        send_word(ilist_pkg::FUNC_SEARCH, VAL_MAX, 7'd0);
        send_word(ilist_pkg::FUNC_DELETE, 32'sd0, 7'd0);
        send_word(ilist_pkg::FUNC_SEARCH, 32'sd0, 7'd0);
    endtask

    // Fills the list to DEPTH, hits the list-full case from both ends, searches
    // the full list and then empties it again.
    task automatic test_fill_to_full();
        while (shadow_len < ilist_pkg::DEPTH)
            send_word(ilist_pkg::FUNC_INSERT, $urandom,
                      ilist_pkg::POS_W'($urandom_range(0, shadow_len)));
        send_word(ilist_pkg::FUNC_INSERT, 32'sd5, 7'd0);
        send_word(ilist_pkg::FUNC_INSERT, VAL_MIN, 7'd127);
        send_word(ilist_pkg::FUNC_SEARCH, shadow_words[ilist_pkg::DEPTH - 1], 7'd0);
        send_word(ilist_pkg::FUNC_SEARCH, shadow_words[0], 7'd127);
        send_word(ilist_pkg::FUNC_DELETE, 32'sd0, 7'd127);
        send_word(ilist_pkg::FUNC_INSERT, VAL_MAX, 7'd127);
        send_word(ilist_pkg::FUNC_SEARCH, VAL_MAX, 7'd0);
        while (shadow_len > 0)
            send_word(ilist_pkg::FUNC_DELETE, $urandom,
                      ilist_pkg::POS_W'($urandom_range(0, shadow_len - 1)));
        send_word(ilist_pkg::FUNC_DELETE, 32'sd0, 7'd0);
    endtask

    // Random traffic in bursts. Each burst leans toward growing, shrinking,
    // mixing or searching, so the list length sweeps its whole range and long
    // shifts and searches happen often. Most positions are legal; the rest are
    // drawn over the whole field to reach the range errors.
    task automatic test_random_ops(input int item_total);
        int                                 sent;
        int                                 mode;
        int                                 burst;
        int                                 roll;
        int                                 insert_pct;
        int                                 delete_pct;
        logic [ilist_pkg::FUNC_W-1:0]       func;
        logic signed [ilist_pkg::VAL_W-1:0] value;
        logic [ilist_pkg::POS_W-1:0]        position;
        sent = 0;
        while (sent < item_total) begin
            mode      = $urandom_range(0, 3);
            burst     = $urandom_range(20, 120);
            if (burst > item_total - sent)
                burst = item_total - sent;
            req_quiet = ($urandom_range(0, 3) == 0);
            case (mode)
                0:       begin insert_pct = 70; delete_pct = 15; end
                1:       begin insert_pct = 15; delete_pct = 70; end
                2:       begin insert_pct = 35; delete_pct = 35; end
                default: begin insert_pct = 15; delete_pct = 15; end
            endcase
            repeat (burst) begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    func = FUNC_UNUSED;
                else if (roll < 2 + insert_pct)
                    func = ilist_pkg::FUNC_INSERT;
                else if (roll < 2 + insert_pct + delete_pct)
                    func = ilist_pkg::FUNC_DELETE;
                else
                    func = ilist_pkg::FUNC_SEARCH;

                // Half the searches look for a value that is on the list. Small
                // values repeat often, so duplicates build up as well.
                if (func == ilist_pkg::FUNC_SEARCH && shadow_len > 0
                        && $urandom_range(0, 1) == 1) begin
                    value = shadow_words[$urandom_range(0, shadow_len - 1)];
                end else begin
                    case ($urandom_range(0, 5))
                        0:       value = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
                        1, 2:    value = $signed(32'($urandom_range(0, 15))) - 32'sd8;
                        default: value = $urandom;
                    endcase
                end

                roll = $urandom_range(0, 9);
                if (roll == 0 || (func == ilist_pkg::FUNC_DELETE && shadow_len == 0))
                    position = ilist_pkg::POS_W'($urandom_range(0, 127));
                else if (roll == 1)
                    position = ilist_pkg::POS_W'(shadow_len);
                else if (func == ilist_pkg::FUNC_INSERT)
                    position = ilist_pkg::POS_W'($urandom_range(0,
                                   (shadow_len < 127) ? shadow_len : 127));
                else if (func == ilist_pkg::FUNC_DELETE)
                    position = ilist_pkg::POS_W'($urandom_range(0, shadow_len - 1));
                else
                    position = ilist_pkg::POS_W'($urandom_range(0, 127));

                send_word(func, value, position);
                sent++;
            end
        end
    endtask

    // Response side: stalls at random, takes each response word and checks it
    // against the oldest owed response. Fields are captured mid-cycle while
    // valid and ready are both high and the edge that follows takes the word.
    initial begin : response_checker
        t_list_result got;
        t_list_result want;
        int           stall;
        rsp_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_gap(rsp_quiet);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(negedge i_clk);
            while (rsp_if.valid !== 1'b1) @(negedge i_clk);
            got.status = rsp_if.status;
            got.found  = rsp_if.found;
            got.length = rsp_if.length;
            @(posedge i_clk);
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf(
                    "response word with none owed: status=%0d found=%0d length=%0d",
                    got.status, got.found, got.length));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
                if (got.found !== want.found)
                    report_mismatch($sformatf("found %0b, wanted %0b", got.found, want.found));
                if (got.length !== want.length)
                    report_mismatch($sformatf("length %0d, wanted %0d", got.length, want.length));
            end
            // Now and then switch between stalling and taking words back to back.
            if ($urandom_range(0, 63) == 0)
                rsp_quiet = !rsp_quiet;
        end
    end

    // Hang detector: counts edges at which no word moves on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d cycles with no word moved", idle_cycles);
            $display("tb_indexed_list_insert_delete_search_core failed");
            $finish;
        end
    end

    // Main sequence. Between the tests the sender holds off until every owed
    // response has come back, so the block is seen going fully idle.
    initial begin : stimulus
        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.func     <= ilist_pkg::FUNC_INSERT;
        req_if.value    <= '0;
        req_if.position <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        wait_for_results();
        test_fill_to_full();
        wait_for_results();
        test_random_ops(RANDOM_ITEMS);
        wait_for_results();

        // Any stray response word after the last owed one still gets flagged.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb_indexed_list_insert_delete_search_core passed");
        else
            $display("tb_indexed_list_insert_delete_search_core failed");
        $finish;
    end

endmodule
